### hdl/pech_pkg.sv
// pech_pkg: shared types and constants for the calibration histogrammer
// no dependencies
`default_nettype none
package pech_pkg;
    localparam logic [1:0] MODE_EVENT = 2'd0;
    localparam logic [1:0] MODE_LOAD  = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;
    localparam logic [1:0] MODE_NONE  = 2'd3;

    typedef struct packed {
        logic [1:0]         mode;
        logic [1:0]         module_req;
        logic [3:0]         channel;
        logic [15:0]        adc_value;
        logic signed [7:0]  dither;
        logic [2:0]         coef_order;
        logic signed [63:0] coef_value;
        logic [11:0]        bin_address;
    } t_req;

    typedef struct packed {
        logic signed [24:0] calibrated_energy;
        logic [11:0]        bin_index;
        logic [31:0]        bin_count;
        logic               out_of_range;
    } t_rsp;
endpackage
`default_nettype wire

### hdl/pech_if.sv
// pech_if: valid/ready channel carrying one payload beat
// depends on nothing; payload type is a parameter
`default_nettype none
interface pech_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### hdl/pech_fifo.sv
// pech_fifo: two-entry queue between front and back
// depends on pech_pkg
`default_nettype none
module pech_fifo import pech_pkg::*; (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_push,
    input  t_req i_data,
    output logic o_full,
    input  wire  i_pop,
    output logic o_empty,
    output t_req o_data
);
    t_req       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    // pointer and count update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end
endmodule
`default_nettype wire

### hdl/pech_back.sv
// pech_back: coefficient table, horner evaluation and histogram update
// depends on pech_pkg
`default_nettype none
module pech_back import pech_pkg::*; #(
    parameter int MODULES = 4,
    parameter int CHANNELS_PER_MODULE = 16,
    parameter int BINS = 4096,
    parameter int COUNT_WIDTH = 32
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_empty,
    input  t_req i_req,
    output logic o_pop,
    output logic o_busy_clr,
    output logic o_valid,
    input  wire  i_ready,
    output t_rsp o_rsp
);
    localparam int NCH   = MODULES * CHANNELS_PER_MODULE;
    localparam int SELW  = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int BINW  = $clog2(BINS);
    localparam int CDEP  = NCH * 5;
    localparam int CAW   = $clog2(CDEP);
    localparam int HDEP  = NCH * BINS;
    localparam int HAW   = $clog2(HDEP);
    localparam int ACCW  = 192;
    localparam int LIMBS = ACCW / 32;
    localparam int EW    = ACCW - 88;
    localparam logic [COUNT_WIDTH-1:0] CMAX = '1;
    localparam logic signed [EW-1:0] E_MIN = EW'(-16777216);
    localparam logic signed [EW-1:0] E_MAX = EW'(16777215);
    localparam logic signed [EW-1:0] E_TOP = EW'(BINS * 256);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_CRD, S_CLD, S_MUL, S_EVAL, S_HRD, S_HWR, S_OUT
    } t_state;

    t_state r_state;
    logic [63:0] r_coef [CDEP];
    logic [COUNT_WIDTH-1:0] r_hist [HDEP];
    logic [63:0] r_cq;
    logic [COUNT_WIDTH-1:0] r_hq;
    logic [HAW-1:0] r_clr;
    logic [CAW-1:0] r_craddr;
    logic [HAW-1:0] r_haddr;
    logic [2:0] r_k;
    logic [2:0] r_limb;
    logic [ACCW-1:0] r_acc;
    logic [ACCW-1:0] r_cs;
    logic signed [24:0] r_x;
    logic signed [25:0] r_pc;
    logic r_rc;
    logic r_valid, r_read;
    t_rsp r_res;
    t_rsp r_rsp;
    logic [SELW-1:0] r_sel;

    logic ok;
    logic [SELW-1:0] sel;
    logic signed [24:0] x;
    logic [ACCW-1:0] cfull, calign;
    logic signed [57:0] pp, t;
    logic [32:0] rsum;
    logic signed [EW-1:0] e8;
    logic [BINW-1:0] ebin;
    logic out_free;
    logic cwe;
    logic [CAW-1:0] cwa;
    logic hwe;
    logic [HAW-1:0] hwa;
    logic [COUNT_WIDTH-1:0] hwd, cnt_inc;

    // counts wider than the result field read as all ones
    function automatic logic [31:0] sat32(input logic [COUNT_WIDTH-1:0] v);
        logic [COUNT_WIDTH+31:0] w;
        w = {32'd0, v};
        return (w[COUNT_WIDTH+31:32] != '0) ? 32'hFFFFFFFF : w[31:0];
    endfunction

    assign ok  = (32'(i_req.module_req) < MODULES) && (32'(i_req.channel) < CHANNELS_PER_MODULE);
    assign sel = SELW'(32'(i_req.module_req) * CHANNELS_PER_MODULE + 32'(i_req.channel));
    assign x   = $signed({1'b0, i_req.adc_value, 8'd0})
               + $signed({{17{i_req.dither[7]}}, i_req.dither});

    // coefficient sign-extended and aligned to 2^96 scale: shift 80-20k
    assign cfull = {{(ACCW-64){r_cq[63]}}, r_cq};
    always_comb begin
        case (r_k)
            3'd0:    calign = cfull << 80;
            3'd1:    calign = cfull << 60;
            3'd2:    calign = cfull << 40;
            3'd3:    calign = cfull << 20;
            default: calign = cfull;
        endcase
    end

    // one 32-bit limb per cycle: acc*x modulo 2^192 plus aligned coefficient
    assign pp   = $signed({1'b0, r_acc[31:0]}) * r_x;
    assign t    = pp + $signed({{32{r_pc[25]}}, r_pc});
    assign rsum = {1'b0, t[31:0]} + {1'b0, r_cs[31:0]} + {32'd0, r_rc};

    // energy in q.8 is the sum scaled down by 2^88
    assign e8   = r_acc[ACCW-1:88];
    assign ebin = e8[BINW+7:8];

    assign cnt_inc  = (r_hq == CMAX) ? r_hq : r_hq + COUNT_WIDTH'(1);
    assign out_free = !r_valid || i_ready;

    assign o_pop = (r_state == S_IDLE) && !i_empty;
    assign o_busy_clr = (r_state == S_CLR);
    assign o_valid = r_valid;
    assign o_rsp = r_rsp;

    assign cwe = o_pop && i_req.mode == MODE_LOAD && ok && i_req.coef_order <= 3'd4;
    assign cwa = CAW'(32'(sel) * 5 + 32'(i_req.coef_order));

    // histogram write port: clearing sweep or count update
    always_comb begin
        hwe = 1'b0; hwa = r_haddr; hwd = cnt_inc;
        if (r_state == S_CLR) begin
            hwe = 1'b1; hwa = r_clr; hwd = '0;
        end else if (r_state == S_HWR && !r_read) begin
            hwe = 1'b1;
        end
    end

    // histogram and coefficient memories
    always_ff @(posedge i_clk) begin
        if (hwe) r_hist[hwa] <= hwd;
        r_hq <= r_hist[r_haddr];
        r_cq <= r_coef[r_craddr];
        if (cwe) r_coef[cwa] <= i_req.coef_value;
    end

    // sequencer: five horner passes, each a table read, an align and six limbs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR; r_clr <= '0; r_valid <= 1'b0;
        end else begin
            r_valid <= (r_state == S_OUT && out_free) ? 1'b1 : (r_valid && !i_ready);
            unique case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (32'(r_clr) == HDEP - 1) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (!i_empty) begin
                        r_sel <= sel;
                        r_res <= '0;
                        r_x <= x;
                        r_k <= 3'd4;
                        r_acc <= '0;
                        r_read <= 1'b0;
                        r_craddr <= CAW'(32'(sel) * 5 + 4);
                        case (i_req.mode)
                            MODE_EVENT: begin
                                if (ok) r_state <= S_CRD;
                                else begin
                                    r_res.out_of_range <= 1'b1; r_state <= S_OUT;
                                end
                            end
                            MODE_READ: begin
                                r_res.bin_index <= i_req.bin_address;
                                if (!ok || 32'(i_req.bin_address) >= BINS) begin
                                    r_res.out_of_range <= 1'b1; r_state <= S_OUT;
                                end else begin
                                    r_haddr <= HAW'(32'(sel) * BINS + 32'(i_req.bin_address));
                                    r_read <= 1'b1;
                                    r_state <= S_HRD;
                                end
                            end
                            default: r_state <= S_OUT;
                        endcase
                    end
                end
                S_CRD: begin
                    // table read latency
                    r_state <= S_CLD;
                end
                S_CLD: begin
                    r_cs <= calign;
                    r_pc <= '0;
                    r_rc <= 1'b0;
                    r_limb <= 3'd0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_acc <= {rsum[31:0], r_acc[ACCW-1:32]};
                    r_cs <= {32'd0, r_cs[ACCW-1:32]};
                    r_pc <= t[57:32];
                    r_rc <= rsum[32];
                    r_limb <= r_limb + 3'd1;
                    if (r_limb == 3'(LIMBS - 1)) begin
                        if (r_k == 3'd0) begin
                            r_state <= S_EVAL;
                        end else begin
                            r_k <= r_k - 3'd1;
                            r_craddr <= r_craddr - CAW'(1);
                            r_state <= S_CRD;
                        end
                    end
                end
                S_EVAL: begin
                    if (e8 < E_MIN) r_res.calibrated_energy <= 25'h1000000;
                    else if (e8 > E_MAX) r_res.calibrated_energy <= 25'h0FFFFFF;
                    else r_res.calibrated_energy <= e8[24:0];
                    if (e8[EW-1] || e8 >= E_TOP) begin
                        r_res.out_of_range <= 1'b1; r_state <= S_OUT;
                    end else begin
                        r_res.bin_index <= 12'(ebin);
                        r_haddr <= HAW'(32'(r_sel) * BINS + 32'(ebin));
                        r_state <= S_HRD;
                    end
                end
                S_HRD: begin
                    r_state <= S_HWR;
                end
                S_HWR: begin
                    // r_hq now valid; events report the count after the update
                    r_res.bin_count <= r_read ? sat32(r_hq) : sat32(cnt_inc);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_rsp <= r_res; r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

### hdl/poly_energy_calib_histogrammer_top.sv
// poly_energy_calib_histogrammer_top: per-channel calibrated energy histogrammer
// uses:
//   i_req (sink): mode, module, channel, raw energy, dither, coefficient load, bin address
//   o_rsp (source): calibrated energy, bin index, bin count, out-of-range flag
// one result beat per request beat, in order
// an event runs five horner passes: table read, align, then six 32-bit
// limbs through one 33x25 multiplier; the back end takes one item at a time
// a two-entry queue takes requests while the back end works
// after reset the histogram memory is swept to zero, one bin per cycle;
// no request is taken meanwhile
// a stalled result sits in the output register; the back end finishes the
// next item and waits, the queue fills, then i_req.ready drops
// coefficients must be loaded before events for that channel
`default_nettype none
module poly_energy_calib_histogrammer_top import pech_pkg::*; #(
    parameter int MODULES = 4,
    parameter int CHANNELS_PER_MODULE = 16,
    parameter int BINS = 4096,
    parameter int COUNT_WIDTH = 32
) (
    input wire i_clk,
    input wire i_rst_n,
    pech_if.sink   i_req,
    pech_if.source o_rsp
);
    logic full, empty, pop, clr;
    t_req q;

    assign i_req.ready = !full && !clr;

    // request queue
    pech_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(i_req.valid && i_req.ready), .i_data(i_req.data), .o_full(full),
        .i_pop(pop), .o_empty(empty), .o_data(q)
    );

    // execution
    pech_back #(
        .MODULES(MODULES), .CHANNELS_PER_MODULE(CHANNELS_PER_MODULE),
        .BINS(BINS), .COUNT_WIDTH(COUNT_WIDTH)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_empty(empty), .i_req(q), .o_pop(pop),
        .o_busy_clr(clr), .o_valid(o_rsp.valid), .i_ready(o_rsp.ready), .o_rsp(o_rsp.data)
    );

    a_no_accept_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clr |-> !i_req.ready) else $error("request taken during clear");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !empty) else $error("pop from empty queue");
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.ready) |=> (o_rsp.valid && $stable(o_rsp.data)))
        else $error("result beat changed while stalled");
endmodule
`default_nettype wire
